[design/sfrp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sfrp_pkg
// Shared types and constants of the serial frame resync parser.
// ----------------------------------------------------------------------------
package sfrp_pkg;

    localparam int unsigned WIN_DEPTH = 9;
    localparam int unsigned CNT_W     = 4;
    localparam int unsigned POS_W     = 3;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned REG_IDX_W = 3;
    localparam int unsigned OUT_W     = 24;

    localparam logic [BYTE_W-1:0] LEN_VALUE = 8'd3;

    // Configuration register indexes.
    localparam logic [REG_IDX_W-1:0] REG_HEADER_FIRST  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_HEADER_SECOND = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_TAIL_FIRST    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_TAIL_SECOND   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_COMMAND_A     = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_COMMAND_B     = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_COMMAND_C     = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_COMMAND_D     = 3'd7;

    typedef struct packed {
        logic [BYTE_W-1:0] header_first;
        logic [BYTE_W-1:0] header_second;
        logic [BYTE_W-1:0] tail_first;
        logic [BYTE_W-1:0] tail_second;
        logic [BYTE_W-1:0] command_code_a;
        logic [BYTE_W-1:0] command_code_b;
        logic [BYTE_W-1:0] command_code_c;
        logic [BYTE_W-1:0] command_code_d;
    } cfg_t;

    typedef struct packed {
        logic             idle;
        logic             emit;
        logic [CNT_W-1:0] count;
    } scan_stat_t;

endpackage
`default_nettype wire

[design/sfrp_intake.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sfrp_intake
// Front end: accepts received words and holds them in a short queue so that
// the window engine can stall without back-pressuring the stream at once.
// ----------------------------------------------------------------------------
module sfrp_intake
    import sfrp_pkg::*;
#(
    parameter int unsigned DEPTH = 4
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [BYTE_W-1:0]               s_tdata,
    output logic                                 q_valid,
    input  wire logic                            q_ready,
    output logic [BYTE_W-1:0]                    q_byte,
    output logic [$clog2(DEPTH+1)-1:0]           level
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned LVL_W = $clog2(DEPTH + 1);

    logic [BYTE_W-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [LVL_W-1:0]  level_reg, level_next;
    logic              push, pop;

    assign s_tready = (level_reg != LVL_W'(DEPTH));
    assign q_valid  = (level_reg != '0);
    assign q_byte   = mem_reg[rd_ptr_reg];
    assign level    = level_reg;
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            level_next = level_reg + 1'b1;
        end else if (pop && !push) begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= s_tdata;
        end
    end

endmodule
`default_nettype wire

[design/sfrp_scan.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sfrp_scan
// Back end, owner of the output register: appends one queued word to the
// nine-byte window, then takes one scan step per cycle (header search, drop,
// length, checksum, tail, command checks) till settled, stalling on a full output.
// ----------------------------------------------------------------------------
module sfrp_scan
    import sfrp_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire cfg_t              cfg,
    input  wire logic              q_valid,
    output logic                   q_ready,
    input  wire logic [BYTE_W-1:0] q_byte,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [OUT_W-1:0]       m_tdata,
    output scan_stat_t             stat
);

    localparam int unsigned WIN_W = WIN_DEPTH * BYTE_W;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [WIN_W-1:0]  win_reg, win_next;
    logic              out_valid_reg;
    logic [OUT_W-1:0]  out_data_reg;

    logic [WIN_DEPTH-2:0] hdr_hit;
    logic                 found;
    logic [POS_W-1:0]     pos;
    logic [CNT_W-1:0]     shift_amt;
    logic [WIN_W-1:0]     win_shift;
    logic [BYTE_W-1:0]    last_byte;
    logic [BYTE_W-1:0]    b2, b3, b4, b5, b6, b7, b8;
    logic [BYTE_W-1:0]    sum;
    logic                 known_cmd, frame_ok, out_free, emit;

    assign b2 = win_reg[2*BYTE_W +: BYTE_W];
    assign b3 = win_reg[3*BYTE_W +: BYTE_W];
    assign b4 = win_reg[4*BYTE_W +: BYTE_W];
    assign b5 = win_reg[5*BYTE_W +: BYTE_W];
    assign b6 = win_reg[6*BYTE_W +: BYTE_W];
    assign b7 = win_reg[7*BYTE_W +: BYTE_W];
    assign b8 = win_reg[8*BYTE_W +: BYTE_W];

    assign sum       = b2 ^ b3 ^ b4 ^ b5;
    assign known_cmd = (b5 == cfg.command_code_a) || (b5 == cfg.command_code_b) ||
                       (b5 == cfg.command_code_c) || (b5 == cfg.command_code_d);
    assign frame_ok  = (b7 == cfg.tail_first) && (b8 == cfg.tail_second) &&
                       (b6 == sum) && known_cmd;
    assign out_free  = !out_valid_reg || m_tready;

    // Header pair search over the valid part of the window; lowest hit wins.
    always_comb begin
        for (int i = 0; i < WIN_DEPTH - 1; i++) begin
            hdr_hit[i] = (win_reg[i*BYTE_W +: BYTE_W] == cfg.header_first) &&
                         (win_reg[(i+1)*BYTE_W +: BYTE_W] == cfg.header_second) &&
                         (CNT_W'(i + 1) < count_reg);
        end
        found = |hdr_hit;
        pos   = '0;
        for (int i = WIN_DEPTH - 2; i >= 0; i--) begin
            if (hdr_hit[i]) begin
                pos = POS_W'(i);
            end
        end
    end

    always_comb begin
        last_byte = '0;
        for (int j = 0; j < WIN_DEPTH; j++) begin
            if (CNT_W'(j + 1) == count_reg) begin
                last_byte = win_reg[j*BYTE_W +: BYTE_W];
            end
        end
    end

    // One shifter serves every drop: by the header offset, otherwise by one.
    assign shift_amt = (state_reg == ST_SCAN && pos != '0) ? CNT_W'(pos) : CNT_W'(1);
    assign win_shift = win_reg >> {shift_amt, 3'b000};

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        win_next   = win_reg;
        q_ready    = 1'b0;
        emit       = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                q_ready = 1'b1;
                if (q_valid) begin
                    state_next = ST_SCAN;
                    if (count_reg >= CNT_W'(WIN_DEPTH)) begin
                        win_next = win_shift;
                        win_next[(WIN_DEPTH-1)*BYTE_W +: BYTE_W] = q_byte;
                        count_next = CNT_W'(WIN_DEPTH);
                    end else begin
                        for (int j = 0; j < WIN_DEPTH; j++) begin
                            if (CNT_W'(j) == count_reg) begin
                                win_next[j*BYTE_W +: BYTE_W] = q_byte;
                            end
                        end
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                if (count_reg < CNT_W'(2)) begin
                    state_next = ST_IDLE;
                end else if (!found) begin
                    // No header pair: keep only a trailing first header byte.
                    state_next = ST_IDLE;
                    if (last_byte == cfg.header_first) begin
                        win_next[0 +: BYTE_W] = last_byte;
                        count_next = CNT_W'(1);
                    end else begin
                        count_next = '0;
                    end
                end else if (pos != '0) begin
                    win_next   = win_shift;
                    count_next = count_reg - shift_amt;
                end else if (count_reg < CNT_W'(3)) begin
                    state_next = ST_IDLE;
                end else if (b2 != LEN_VALUE) begin
                    win_next   = win_shift;
                    count_next = count_reg - 1'b1;
                end else if (count_reg < CNT_W'(WIN_DEPTH)) begin
                    state_next = ST_IDLE;
                end else if (frame_ok) begin
                    // Hold the frame until the output register is free.
                    if (out_free) begin
                        emit       = 1'b1;
                        count_next = '0;
                        state_next = ST_IDLE;
                    end
                end else begin
                    win_next   = win_shift;
                    count_next = count_reg - 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        win_reg <= win_next;
        if (emit) begin
            out_data_reg <= {b5, b3, b4};
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign stat.idle  = (state_reg == ST_IDLE);
    assign stat.emit  = emit;
    assign stat.count = count_reg;

endmodule
`default_nettype wire

[design/serial_frame_resync_parser_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// serial_frame_resync_parser_core
// Hunts a byte stream for nine-byte frames with XOR checksum and reports the
// sequence and command of each good frame.
// ----------------------------------------------------------------------------
// Each received word goes through a short input queue into a window engine
// that appends the word and then takes one scan step per cycle (a header
// realignment, a one-byte drop or the final frame check), the frame check
// waiting while a result still sits on the output; the engine takes no new
// word until its window has settled, and it has a single shift-and-compare
// step. Words keep being accepted into the queue while it has room, also
// while the engine scans or while a result waits on the output.
// Configuration registers are written through cfg_we/cfg_index/cfg_wdata and
// should only change while the stream is quiet.
module serial_frame_resync_parser_core
    import sfrp_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [BYTE_W-1:0]    s_tdata,    // [7:0] rx_byte
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [OUT_W-1:0]          m_tdata,    // [15:0] frame_sequence, [23:16] frame_command
    input  wire logic                 cfg_we,
    input  wire logic [REG_IDX_W-1:0] cfg_index,
    input  wire logic [BYTE_W-1:0]    cfg_wdata
);

    localparam int unsigned LVL_W = $clog2(QUEUE_DEPTH + 1);

    cfg_t              cfg_reg;
    logic              q_valid, q_ready;
    logic [BYTE_W-1:0] q_byte;
    logic [LVL_W-1:0]  q_level;
    scan_stat_t        scan_stat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.header_first   <= 8'hAA;
            cfg_reg.header_second  <= 8'h55;
            cfg_reg.tail_first     <= 8'h00;
            cfg_reg.tail_second    <= 8'h00;
            cfg_reg.command_code_a <= 8'h01;
            cfg_reg.command_code_b <= 8'h02;
            cfg_reg.command_code_c <= 8'h03;
            cfg_reg.command_code_d <= 8'h04;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_HEADER_FIRST:  cfg_reg.header_first   <= cfg_wdata;
                REG_HEADER_SECOND: cfg_reg.header_second  <= cfg_wdata;
                REG_TAIL_FIRST:    cfg_reg.tail_first     <= cfg_wdata;
                REG_TAIL_SECOND:   cfg_reg.tail_second    <= cfg_wdata;
                REG_COMMAND_A:     cfg_reg.command_code_a <= cfg_wdata;
                REG_COMMAND_B:     cfg_reg.command_code_b <= cfg_wdata;
                REG_COMMAND_C:     cfg_reg.command_code_c <= cfg_wdata;
                REG_COMMAND_D:     cfg_reg.command_code_d <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    sfrp_intake #(
        .DEPTH(QUEUE_DEPTH)
    ) u_intake (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_byte   (q_byte),
        .level    (q_level)
    );

    sfrp_scan u_scan (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_byte   (q_byte),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .stat     (scan_stat)
    );

`ifndef ASSERT_OFF
    // Between words the window never holds a complete nine bytes.
    a_window_settled: assert property (@(posedge aclk) disable iff (!aresetn)
        scan_stat.idle |-> (scan_stat.count <= CNT_W'(WIN_DEPTH - 1)))
        else $error("window left full after scan");

    // A reported frame empties the window.
    a_emit_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        scan_stat.emit |=> (scan_stat.count == '0))
        else $error("window not cleared after frame");

    // A frame is only reported when the output register can take it.
    a_emit_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        scan_stat.emit |-> (!m_tvalid || m_tready))
        else $error("pending result overwritten");

    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_level <= LVL_W'(QUEUE_DEPTH))
        else $error("input queue overflow");
`endif

endmodule
`default_nettype wire

[bench/tb_serial_frame_resync_parser_core.sv]
// ----------------------------------------------------------------------------
// tb_serial_frame_resync_parser_core
// Self-checking bench for the serial frame resync parser. A byte stream of
// good, damaged and cut-off frames mixed with noise is pushed through the
// input channel under several header, tail and command settings. A built-in
// window predictor works out each decoded frame, and the frames coming out of
// the result channel are compared against it in order.
// ----------------------------------------------------------------------------
module tb_serial_frame_resync_parser_core
    import sfrp_pkg::*;
();

    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned SETTLE_CYCLES  = 64;
    localparam int unsigned PHASE_BYTES    = 320;
    localparam int unsigned NUM_PHASES     = 6;

    typedef struct packed {
        logic [15:0]       seq;
        logic [BYTE_W-1:0] cmd;
    } frame_fields_t;

    typedef enum int unsigned {
        FLAW_NONE,
        FLAW_LENGTH,
        FLAW_CHECKSUM,
        FLAW_TAIL_FIRST,
        FLAW_TAIL_SECOND,
        FLAW_COMMAND,
        FLAW_HEADER
    } frame_flaw_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [BYTE_W-1:0]    s_tdata   = '0;   // [7:0] rx_byte
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [OUT_W-1:0]     m_tdata;          // [15:0] frame_sequence, [23:16] frame_command
    logic                 cfg_we    = 1'b0;
    logic [REG_IDX_W-1:0] cfg_index = '0;
    logic [BYTE_W-1:0]    cfg_wdata = '0;

    // Predictor state.
    cfg_t              model_cfg;
    logic [BYTE_W-1:0] win_bytes [WIN_DEPTH];
    int unsigned       win_fill = 0;

    logic [BYTE_W-1:0] stream_bytes_pending [$];
    frame_fields_t     frames_expected [$];
    int unsigned       bytes_queued   = 0;
    int unsigned       bytes_accepted = 0;
    int unsigned       error_count    = 0;
    int unsigned       idle_cycles    = 0;

    int unsigned tx_gap, tx_calm, rx_stall, rx_calm;

    serial_frame_resync_parser_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    function automatic cfg_t reset_cfg();
        cfg_t c;
        c.header_first   = 8'hAA;
        c.header_second  = 8'h55;
        c.tail_first     = 8'h00;
        c.tail_second    = 8'h00;
        c.command_code_a = 8'h01;
        c.command_code_b = 8'h02;
        c.command_code_c = 8'h03;
        c.command_code_d = 8'h04;
        return c;
    endfunction

    function automatic bit is_known_cmd(logic [BYTE_W-1:0] c);
        return c == model_cfg.command_code_a || c == model_cfg.command_code_b ||
               c == model_cfg.command_code_c || c == model_cfg.command_code_d;
    endfunction

    function automatic void shift_window(int unsigned n);
        if (n >= win_fill) begin
            win_fill = 0;
        end else begin
            for (int unsigned i = 0; i + n < win_fill; i++)
                win_bytes[i] = win_bytes[i + n];
            win_fill -= n;
        end
    endfunction

    // Appends one received byte and rescans the window until it settles.
    // Returns 1 when a complete good frame was found.
    function automatic bit absorb_rx_byte(input logic [BYTE_W-1:0] b,
                                          output frame_fields_t got);
        int unsigned       hdr_pos;
        logic [BYTE_W-1:0] sum;
        bit                found;
        found = 1'b0;
        got   = '0;
        if (win_fill >= WIN_DEPTH)
            shift_window(win_fill - WIN_DEPTH + 1);
        win_bytes[win_fill] = b;
        win_fill++;
        while (win_fill >= 2) begin
            hdr_pos = win_fill;
            for (int unsigned i = 0; i + 1 < win_fill; i++) begin
                if (win_bytes[i] == model_cfg.header_first &&
                    win_bytes[i + 1] == model_cfg.header_second) begin
                    hdr_pos = i;
                    break;
                end
            end
            if (hdr_pos == win_fill) begin
                // Only a trailing first header byte can still start a frame.
                if (win_bytes[win_fill - 1] == model_cfg.header_first) begin
                    win_bytes[0] = win_bytes[win_fill - 1];
                    win_fill = 1;
                end else begin
                    win_fill = 0;
                end
                break;
            end
            shift_window(hdr_pos);
            if (win_fill < 3)
                break;
            if (win_bytes[2] != LEN_VALUE) begin
                shift_window(1);
                continue;
            end
            if (win_fill < WIN_DEPTH)
                break;
            sum = win_bytes[2] ^ win_bytes[3] ^ win_bytes[4] ^ win_bytes[5];
            if (!found && win_bytes[7] == model_cfg.tail_first &&
                win_bytes[8] == model_cfg.tail_second && win_bytes[6] == sum &&
                is_known_cmd(win_bytes[5])) begin
                got.seq = {win_bytes[3], win_bytes[4]};
                got.cmd = win_bytes[5];
                found = 1'b1;
                shift_window(WIN_DEPTH);
            end else begin
                shift_window(1);
            end
        end
        return found;
    endfunction

    function automatic void queue_byte(logic [BYTE_W-1:0] b);
        stream_bytes_pending.insert(stream_bytes_pending.size(), b);
        bytes_queued++;
    endfunction

    function automatic logic [BYTE_W-1:0] nonzero_byte();
        return BYTE_W'($urandom_range(1, 255));
    endfunction

    function automatic logic [BYTE_W-1:0] pick_known_cmd();
        case ($urandom_range(0, 3))
            0: return model_cfg.command_code_a;
            1: return model_cfg.command_code_b;
            2: return model_cfg.command_code_c;
            default: return model_cfg.command_code_d;
        endcase
    endfunction

    // Queues the first keep bytes of a frame, damaged as flaw says.
    function automatic void queue_frame(logic [15:0] seq, logic [BYTE_W-1:0] cmd,
                                        frame_flaw_t flaw, int unsigned keep);
        logic [BYTE_W-1:0] fb [WIN_DEPTH];
        logic [BYTE_W-1:0] len_byte;
        len_byte = LEN_VALUE;
        if (flaw == FLAW_LENGTH)
            len_byte = LEN_VALUE ^ nonzero_byte();
        if (flaw == FLAW_COMMAND) begin
            do cmd = BYTE_W'($urandom); while (is_known_cmd(cmd));
        end
        fb[0] = model_cfg.header_first;
        fb[1] = model_cfg.header_second;
        fb[2] = len_byte;
        fb[3] = seq[15:8];
        fb[4] = seq[7:0];
        fb[5] = cmd;
        fb[6] = len_byte ^ seq[15:8] ^ seq[7:0] ^ cmd;
        fb[7] = model_cfg.tail_first;
        fb[8] = model_cfg.tail_second;
        case (flaw)
            FLAW_CHECKSUM:    fb[6] = fb[6] ^ nonzero_byte();
            FLAW_TAIL_FIRST:  fb[7] = fb[7] ^ nonzero_byte();
            FLAW_TAIL_SECOND: fb[8] = fb[8] ^ nonzero_byte();
            FLAW_HEADER:      fb[1] = fb[1] ^ nonzero_byte();
            default: ;
        endcase
        for (int unsigned i = 0; i < keep && i < WIN_DEPTH; i++)
            queue_byte(fb[i]);
    endfunction

    function automatic void queue_random_traffic(int unsigned budget);
        int unsigned target;
        int unsigned r;
        target = bytes_queued + budget;
        while (bytes_queued < target) begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                queue_frame(16'($urandom), pick_known_cmd(), FLAW_NONE, WIN_DEPTH);
            end else if (r < 78) begin
                queue_frame(16'($urandom), pick_known_cmd(),
                            frame_flaw_t'($urandom_range(1, 6)), WIN_DEPTH);
            end else if (r < 88) begin
                queue_frame(16'($urandom), pick_known_cmd(), FLAW_NONE,
                            $urandom_range(1, WIN_DEPTH - 1));
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    if ($urandom_range(0, 4) == 0)
                        queue_byte(model_cfg.header_first);
                    else
                        queue_byte(BYTE_W'($urandom));
                end
            end
        end
    endfunction

    // Mostly back-to-back, some short gaps, a few long ones, and now and then
    // a long stretch with no gaps at all.
    function automatic int unsigned pick_gap(inout int unsigned calm);
        int unsigned r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 95) begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        return $urandom_range(10, 40);
    endfunction

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx,
                             input logic [BYTE_W-1:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic apply_config(input cfg_t c);
        write_reg(REG_HEADER_FIRST,  c.header_first);
        write_reg(REG_HEADER_SECOND, c.header_second);
        write_reg(REG_TAIL_FIRST,    c.tail_first);
        write_reg(REG_TAIL_SECOND,   c.tail_second);
        write_reg(REG_COMMAND_A,     c.command_code_a);
        write_reg(REG_COMMAND_B,     c.command_code_b);
        write_reg(REG_COMMAND_C,     c.command_code_c);
        write_reg(REG_COMMAND_D,     c.command_code_d);
        model_cfg = c;
    endtask

    // Waits until every queued word is taken and every frame has come out,
    // then lets the engine finish any scan that produces no frame.
    task automatic drain_and_settle();
        while (bytes_accepted != bytes_queued || frames_expected.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic cfg_t phase_cfg(int unsigned phase);
        cfg_t c;
        c = cfg_t'({$urandom, $urandom});
        case (phase)
            1: c = '0;
            2: c = '1;
            4: begin
                c.header_second = c.header_first;
                c.tail_first    = 8'hFF;
                c.tail_second   = 8'h00;
            end
            5: c = reset_cfg();
            default: ;
        endcase
        return c;
    endfunction

    // Input side driver.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            tx_gap   = 0;
            tx_calm  = 0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid)
                tx_gap = pick_gap(tx_calm);
            if (tx_gap > 0) begin
                tx_gap--;
                s_tvalid <= 1'b0;
            end else if (stream_bytes_pending.size() > 0) begin
                s_tvalid <= 1'b1;
                s_tdata  <= stream_bytes_pending.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result side backpressure.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_stall = 0;
            rx_calm  = 0;
        end else if (rx_stall > 0) begin
            rx_stall--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            rx_stall = pick_gap(rx_calm);
        end
    end

    // Monitor: predicts on every accepted word, checks every accepted result.
    always @(posedge aclk) begin
        frame_fields_t predicted;
        frame_fields_t oldest;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                bytes_accepted++;
                if (absorb_rx_byte(s_tdata, predicted))
                    frames_expected.insert(frames_expected.size(), predicted);
            end
            if (m_tvalid && m_tready) begin
                if (frames_expected.size() == 0) begin
                    $error("unexpected frame: frame_sequence %h frame_command %h",
                           m_tdata[15:0], m_tdata[23:16]);
                    error_count++;
                end else begin
                    oldest = frames_expected.pop_front();
                    if (m_tdata[15:0] !== oldest.seq) begin
                        $error("frame_sequence: expected %h, got %h",
                               oldest.seq, m_tdata[15:0]);
                        error_count++;
                    end
                    if (m_tdata[23:16] !== oldest.cmd) begin
                        $error("frame_command: expected %h, got %h",
                               oldest.cmd, m_tdata[23:16]);
                        error_count++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin
        model_cfg = reset_cfg();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // A stray byte, then a kept first header byte that the next frame's
        // header follows, so the scan has to realign.
        queue_byte(8'h00);
        queue_byte(model_cfg.header_first);
        queue_frame(16'hFFFF, model_cfg.command_code_d, FLAW_NONE, WIN_DEPTH);
        queue_frame(16'h0000, model_cfg.command_code_a, FLAW_LENGTH, 3);
        queue_frame(16'h0000, model_cfg.command_code_a, FLAW_CHECKSUM, WIN_DEPTH);

        for (int unsigned phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase > 0) begin
                drain_and_settle();
                apply_config(phase_cfg(phase));
            end
            queue_random_traffic(PHASE_BYTES);
        end
        drain_and_settle();

        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
